>>> src/vst_pkg.sv
package vst_pkg;

   // Grid limits and defaults
   localparam int MAX_NX_DEF = 64;
   localparam int MAX_NY_DEF = 64;
   localparam int MAX_NZ_DEF = 4096;

   // Widest index fields carried between front and back
   localparam int XMAX_W = 10;
   localparam int YMAX_W = 10;
   localparam int ZMAX_W = 16;

   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 4;

   // Register reset values
   localparam logic [6:0]  SIZE_X_RST = 7'd64;
   localparam logic [6:0]  SIZE_Y_RST = 7'd64;
   localparam logic [12:0] SIZE_Z_RST = 13'd64;
   localparam logic [4:0]  GHOST_RST  = 5'd1;

   // Register indexes
   localparam logic [1:0] CSR_SIZE_X = 2'd0;
   localparam logic [1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [1:0] CSR_GHOST  = 2'd3;

   // One classified grid point
   typedef struct packed {
      logic signed [DATA_W-1:0] vel_u;
      logic signed [DATA_W-1:0] vel_v;
      logic signed [DATA_W-1:0] vel_w;
      logic signed [DATA_W-1:0] x_coord;
      logic signed [DATA_W-1:0] y_coord;
      logic signed [DATA_W-1:0] z_coord;
      logic [XMAX_W-1:0]        ci;
      logic [YMAX_W-1:0]        cj;
      logic [ZMAX_W-1:0]        kc;
      logic                     kbit;
      logic                     emit;
      logic                     last;
      logic                     plane_end;
   } item_type;

   // Saturate a 33-bit signed value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/vst_front.sv
module vst_front #(
   parameter int MAX_NX = vst_pkg::MAX_NX_DEF,
   parameter int MAX_NY = vst_pkg::MAX_NY_DEF,
   parameter int MAX_NZ = vst_pkg::MAX_NZ_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [191:0]      req_tdata,
   input  logic              q_full,
   output logic              push,
   output vst_pkg::item_type push_item
);
   localparam int XW  = $clog2(MAX_NX);
   localparam int YW  = $clog2(MAX_NY);
   localparam int ZW  = $clog2(MAX_NZ);
   localparam int M1  = (XW > YW) ? XW : YW;
   localparam int M2  = (M1 > ZW) ? M1 : ZW;
   localparam int CW  = ((M2 > 13) ? M2 : 13) + 3;

   logic [6:0]    size_x_ff, size_y_ff;
   logic [12:0]   size_z_ff;
   logic [4:0]    ghost_ff;
   logic [XW-1:0] ci_ff;
   logic [YW-1:0] cj_ff;
   logic [ZW-1:0] ck_ff;

   logic [CW-1:0] nx, ny, nz, g, ci, cj, kin, kc;
   logic          accept, emit, last, i_end, j_end, k_end;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // Clamp sizes and ghost count
   always_comb begin
      nx = (CW'(size_x_ff) < CW'(3)) ? CW'(3) :
           ((CW'(size_x_ff) > CW'(MAX_NX)) ? CW'(MAX_NX) : CW'(size_x_ff));
      ny = (CW'(size_y_ff) < CW'(3)) ? CW'(3) :
           ((CW'(size_y_ff) > CW'(MAX_NY)) ? CW'(MAX_NY) : CW'(size_y_ff));
      nz = (CW'(size_z_ff) < CW'(3)) ? CW'(3) :
           ((CW'(size_z_ff) > CW'(MAX_NZ)) ? CW'(MAX_NZ) : CW'(size_z_ff));
      g  = (ghost_ff == 5'd0) ? CW'(1) : CW'(ghost_ff);
      ci  = CW'(ci_ff);
      cj  = CW'(cj_ff);
      kin = CW'(ck_ff);
      kc  = kin - CW'(1);
   end

   // Classify the point below this one
   always_comb begin
      emit = (kin != '0) && (ci >= g) && (ci + g < nx) && (cj >= g) && (cj + g < ny) &&
             (kc >= g) && (kc + g < nz);
      last = (ci + g + CW'(1) == nx) && (cj + g + CW'(1) == ny) &&
             (kc + g + CW'(1) == nz);
      i_end = !(ci + CW'(1) < nx);
      j_end = !(cj + CW'(1) < ny);
      k_end = !(kin + CW'(1) < nz);
   end

   // Pack the request into a queue entry
   always_comb begin
      push                = accept;
      push_item.vel_u     = req_tdata[31:0];
      push_item.vel_v     = req_tdata[63:32];
      push_item.vel_w     = req_tdata[95:64];
      push_item.x_coord   = req_tdata[127:96];
      push_item.y_coord   = req_tdata[159:128];
      push_item.z_coord   = req_tdata[191:160];
      push_item.ci        = vst_pkg::XMAX_W'(ci_ff);
      push_item.cj        = vst_pkg::YMAX_W'(cj_ff);
      push_item.kc        = vst_pkg::ZMAX_W'(kc);
      push_item.kbit      = ck_ff[0];
      push_item.emit      = emit;
      push_item.last      = last;
      push_item.plane_end = i_end && j_end;
   end

   // Hold registers, advance counters
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= vst_pkg::SIZE_X_RST;
         size_y_ff <= vst_pkg::SIZE_Y_RST;
         size_z_ff <= vst_pkg::SIZE_Z_RST;
         ghost_ff  <= vst_pkg::GHOST_RST;
         ci_ff     <= '0;
         cj_ff     <= '0;
         ck_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vst_pkg::CSR_SIZE_X: size_x_ff <= csr_wdata[6:0];
            vst_pkg::CSR_SIZE_Y: size_y_ff <= csr_wdata[6:0];
            vst_pkg::CSR_SIZE_Z: size_z_ff <= csr_wdata;
            vst_pkg::CSR_GHOST:  ghost_ff  <= csr_wdata[4:0];
            default: ghost_ff <= ghost_ff;
         endcase
         ci_ff <= '0;
         cj_ff <= '0;
         ck_ff <= '0;
      end else if (accept) begin
         if (!i_end) begin
            ci_ff <= ci_ff + XW'(1);
         end else begin
            ci_ff <= '0;
            if (!j_end) begin
               cj_ff <= cj_ff + YW'(1);
            end else begin
               cj_ff <= '0;
               ck_ff <= k_end ? '0 : ck_ff + ZW'(1);
            end
         end
      end
   end

endmodule

>>> src/vst_queue.sv
module vst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vst_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output vst_pkg::item_type head_item
);
   localparam int PW = $clog2(vst_pkg::QUEUE_DEPTH);

   vst_pkg::item_type entry_ff [vst_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, rd_ff;
   logic [PW:0]       count_ff;

   assign full      = (count_ff == (PW+1)'(vst_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PW'(1);
         if (pop)  rd_ff <= rd_ff + PW'(1);
         if (push && !pop) count_ff <= count_ff + (PW+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PW+1)'(1);
      end
   end

endmodule

>>> src/vst_divider.sv
module vst_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [vst_pkg::DATA_W:0]    num,
   input  logic [vst_pkg::DATA_W:0]           den,
   output logic                               done,
   output logic signed [vst_pkg::DATA_W-1:0]  quot
);
   localparam int DW = vst_pkg::DATA_W;
   localparam int QW = DW + 1 + 16;

   logic [DW+1:0] rem_ff, rem_in, shifted;
   logic [QW-1:0] dq_ff;
   logic [DW:0]   den_ff, mag;
   logic          neg_ff, busy_ff, ge;
   logic [5:0]    cnt_ff;

   assign mag     = num[DW] ? (DW+1)'(-num) : (DW+1)'(num);
   assign shifted = {rem_ff[DW:0], dq_ff[QW-1]};
   assign ge      = (shifted >= {1'b0, den_ff});
   assign rem_in  = ge ? shifted - {1'b0, den_ff} : shifted;

   // One quotient bit per cycle, then saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(QW);
            rem_ff  <= '0;
            dq_ff   <= {mag, 16'h0000};
            den_ff  <= den;
            neg_ff  <= num[DW];
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               rem_ff <= rem_in;
               dq_ff  <= {dq_ff[QW-2:0], ge};
               cnt_ff <= cnt_ff - 6'd1;
            end else begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
               if (neg_ff) begin
                  quot <= (dq_ff >= QW'(64'h80000000)) ? {1'b1, {(DW-1){1'b0}}} :
                          -dq_ff[DW-1:0];
               end else begin
                  quot <= (dq_ff > QW'(64'h7FFFFFFF)) ? {1'b0, {(DW-1){1'b1}}} :
                          dq_ff[DW-1:0];
               end
            end
         end
      end
   end

endmodule

>>> src/vst_back.sv
module vst_back #(
   parameter int MAX_NX = vst_pkg::MAX_NX_DEF,
   parameter int MAX_NY = vst_pkg::MAX_NY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  vst_pkg::item_type head_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [119:0]      rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);
   localparam int XW = $clog2(MAX_NX);
   localparam int YW = $clog2(MAX_NY);
   localparam int AW = 1 + XW + YW;
   localparam int DW = vst_pkg::DATA_W;

   // Derivative slots
   localparam logic [2:0] D_DUDY = 3'd0;
   localparam logic [2:0] D_DUDZ = 3'd1;
   localparam logic [2:0] D_DVDX = 3'd2;
   localparam logic [2:0] D_DVDZ = 3'd3;
   localparam logic [2:0] D_DWDX = 3'd4;
   localparam logic [2:0] D_DWDY = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_SETUP, S_WAIT, S_EMIT, S_WRITE
   } state_type;

   state_type         state_ff;
   vst_pkg::item_type cur_ff;
   logic [2:0]        rd_ff, d_ff;
   logic              err_ff;

   logic [3*DW-1:0]   plane_mem [2**AW];
   logic signed [DW-1:0] x_mem [2**XW];
   logic signed [DW-1:0] y_mem [2**YW];
   logic [3*DW-1:0]   plane_rd_ff;
   logic signed [DW-1:0] x_rd_ff, y_rd_ff;
   logic signed [DW-1:0] zh0_ff, zh1_ff;

   logic signed [DW-1:0] v_e_ff, w_e_ff, v_w_ff, w_w_ff, u_n_ff, w_n_ff, u_s_ff, w_s_ff;
   logic signed [DW-1:0] u_l_ff, v_l_ff, x_e_ff, x_w_ff, y_n_ff, y_s_ff;
   logic signed [DW-1:0] q_ff [6];

   logic [XW-1:0]     ci, ci_p, ci_m;
   logic [YW-1:0]     cj, cj_p, cj_m;
   logic [AW-1:0]     plane_addr, wr_addr;
   logic [XW-1:0]     x_addr;
   logic [YW-1:0]     y_addr;
   logic signed [DW:0] diff, den;
   logic              den_ok, div_start, div_done;
   logic signed [DW-1:0] div_quot;
   logic signed [DW-1:0] vort_x, vort_y, vort_z;

   assign ci   = cur_ff.ci[XW-1:0];
   assign cj   = cur_ff.cj[YW-1:0];
   assign ci_p = ci + XW'(1);
   assign ci_m = ci - XW'(1);
   assign cj_p = cj + YW'(1);
   assign cj_m = cj - YW'(1);
   assign wr_addr = {cur_ff.kbit, cj, ci};

   // Select neighbor address for this read step
   always_comb begin
      unique case (rd_ff)
         3'd0:    plane_addr = {!cur_ff.kbit, cj, ci_p};
         3'd1:    plane_addr = {!cur_ff.kbit, cj, ci_m};
         3'd2:    plane_addr = {!cur_ff.kbit, cj_p, ci};
         3'd3:    plane_addr = {!cur_ff.kbit, cj_m, ci};
         default: plane_addr = wr_addr;
      endcase
      x_addr = (rd_ff == 3'd0) ? ci_p : ci_m;
      y_addr = (rd_ff == 3'd2) ? cj_p : cj_m;
   end

   // Memories: write on retire, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         plane_mem[wr_addr] <= {cur_ff.vel_w, cur_ff.vel_v, cur_ff.vel_u};
         x_mem[ci]          <= cur_ff.x_coord;
         y_mem[cj]          <= cur_ff.y_coord;
      end
      plane_rd_ff <= plane_mem[plane_addr];
      x_rd_ff     <= x_mem[x_addr];
      y_rd_ff     <= y_mem[y_addr];
   end

   // Pick numerator and spacing for the current derivative
   always_comb begin
      unique case (d_ff)
         D_DUDY: begin
            diff = {u_n_ff[DW-1], u_n_ff} - {u_s_ff[DW-1], u_s_ff};
            den  = {y_n_ff[DW-1], y_n_ff} - {y_s_ff[DW-1], y_s_ff};
         end
         D_DUDZ: begin
            diff = {cur_ff.vel_u[DW-1], cur_ff.vel_u} - {u_l_ff[DW-1], u_l_ff};
            den  = {cur_ff.z_coord[DW-1], cur_ff.z_coord} - {zh0_ff[DW-1], zh0_ff};
         end
         D_DVDX: begin
            diff = {v_e_ff[DW-1], v_e_ff} - {v_w_ff[DW-1], v_w_ff};
            den  = {x_e_ff[DW-1], x_e_ff} - {x_w_ff[DW-1], x_w_ff};
         end
         D_DVDZ: begin
            diff = {cur_ff.vel_v[DW-1], cur_ff.vel_v} - {v_l_ff[DW-1], v_l_ff};
            den  = {cur_ff.z_coord[DW-1], cur_ff.z_coord} - {zh0_ff[DW-1], zh0_ff};
         end
         D_DWDX: begin
            diff = {w_e_ff[DW-1], w_e_ff} - {w_w_ff[DW-1], w_w_ff};
            den  = {x_e_ff[DW-1], x_e_ff} - {x_w_ff[DW-1], x_w_ff};
         end
         default: begin
            diff = {w_n_ff[DW-1], w_n_ff} - {w_s_ff[DW-1], w_s_ff};
            den  = {y_n_ff[DW-1], y_n_ff} - {y_s_ff[DW-1], y_s_ff};
         end
      endcase
      den_ok    = !den[DW] && (den != '0);
      div_start = (state_ff == S_SETUP) && den_ok;
   end

   vst_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (diff),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Combine derivatives into the curl
   always_comb begin
      vort_x = vst_pkg::sat33({q_ff[D_DWDY][DW-1], q_ff[D_DWDY]} -
                              {q_ff[D_DVDZ][DW-1], q_ff[D_DVDZ]});
      vort_y = vst_pkg::sat33({q_ff[D_DUDZ][DW-1], q_ff[D_DUDZ]} -
                              {q_ff[D_DWDX][DW-1], q_ff[D_DWDX]});
      vort_z = vst_pkg::sat33({q_ff[D_DVDX][DW-1], q_ff[D_DVDX]} -
                              {q_ff[D_DUDY][DW-1], q_ff[D_DUDY]});
   end

   assign pop = (state_ff == S_IDLE) && !empty;

   // Sequence one point: read, divide, emit, retire; a point that emits nothing only retires
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_tvalid <= 1'b0;
         rd_ff      <= '0;
         d_ff       <= '0;
         err_ff     <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && (state_ff != S_EMIT)) rsp_tvalid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  cur_ff   <= head_item;
                  rd_ff    <= '0;
                  state_ff <= head_item.emit ? S_READ : S_WRITE;
               end
            end
            S_READ: begin
               rd_ff <= rd_ff + 3'd1;
               unique case (rd_ff)
                  3'd1: begin
                     v_e_ff <= plane_rd_ff[2*DW-1:DW];
                     w_e_ff <= plane_rd_ff[3*DW-1:2*DW];
                     x_e_ff <= x_rd_ff;
                  end
                  3'd2: begin
                     v_w_ff <= plane_rd_ff[2*DW-1:DW];
                     w_w_ff <= plane_rd_ff[3*DW-1:2*DW];
                     x_w_ff <= x_rd_ff;
                  end
                  3'd3: begin
                     u_n_ff <= plane_rd_ff[DW-1:0];
                     w_n_ff <= plane_rd_ff[3*DW-1:2*DW];
                     y_n_ff <= y_rd_ff;
                  end
                  3'd4: begin
                     u_s_ff <= plane_rd_ff[DW-1:0];
                     w_s_ff <= plane_rd_ff[3*DW-1:2*DW];
                     y_s_ff <= y_rd_ff;
                  end
                  3'd5: begin
                     u_l_ff   <= plane_rd_ff[DW-1:0];
                     v_l_ff   <= plane_rd_ff[2*DW-1:DW];
                     d_ff     <= D_DUDY;
                     err_ff   <= 1'b0;
                     state_ff <= S_SETUP;
                  end
                  default: ;
               endcase
            end
            S_SETUP: begin
               if (den_ok) begin
                  state_ff <= S_WAIT;
               end else begin
                  q_ff[d_ff] <= '0;
                  err_ff     <= 1'b1;
                  if (d_ff == D_DWDY) state_ff <= S_EMIT;
                  else d_ff <= d_ff + 3'd1;
               end
            end
            S_WAIT: begin
               if (div_done) begin
                  q_ff[d_ff] <= div_quot;
                  if (d_ff == D_DWDY) begin
                     state_ff <= S_EMIT;
                  end else begin
                     d_ff     <= d_ff + 3'd1;
                     state_ff <= S_SETUP;
                  end
               end
            end
            S_EMIT: begin
               if (!rsp_tvalid || rsp_tready) begin
                  rsp_tvalid <= 1'b1;
                  rsp_tdata  <= {cur_ff.kc[11:0], cur_ff.cj[5:0], cur_ff.ci[5:0],
                                 vort_z, vort_y, vort_x};
                  rsp_tlast  <= cur_ff.last;
                  rsp_tuser  <= err_ff;
                  state_ff   <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (cur_ff.plane_end) begin
                  zh0_ff <= zh1_ff;
                  zh1_ff <= cur_ff.z_coord;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> src/vorticity_stencil_3d.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: vel_u,vel_v,vel_w,x,y,z coord
// rsp       out        rsp_tvalid/rsp_tready  tdata: vort_x,y,z,pos_i,j,k; tlast; tuser
// csr       in         csr_we                 csr_index, csr_wdata
//
// A point that completes no interior point only retires. An interior point first
// reads its five plane neighbors, then forms six quotients through one shared
// divider that yields one bit per cycle; a non-positive spacing skips its
// division.
// Reset is synchronous; the plane memories need no clearing pass.
// A four-entry queue decouples request intake from the back end; the result
// register lets the back end finish retiring a point while a result waits.
module vorticity_stencil_3d #(
   parameter int MAX_NX = vst_pkg::MAX_NX_DEF,
   parameter int MAX_NY = vst_pkg::MAX_NY_DEF,
   parameter int MAX_NZ = vst_pkg::MAX_NZ_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // vel_u, vel_v, vel_w, x_coord, y_coord, z_coord
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // vort_x, vort_y, vort_z, pos_i, pos_j, pos_k
   output logic         rsp_tlast,   // last_point
   output logic         rsp_tuser    // spacing_error
);
   logic              push, pop, q_full, q_empty;
   vst_pkg::item_type push_item, head_item;

   vst_front #(.MAX_NX(MAX_NX), .MAX_NY(MAX_NY), .MAX_NZ(MAX_NZ)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   vst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head_item (head_item)
   );

   vst_back #(.MAX_NX(MAX_NX), .MAX_NY(MAX_NY)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/sv/tb_vorticity_stencil_3d.sv
`timescale 1ns / 1ps

module tb_vorticity_stencil_3d;

   localparam int PLANE      = 64 * 64;
   localparam int LIMIT      = 3000000;
   localparam int SETTLE     = 400;
   localparam int RAND_ITEMS = 100;

   // Velocity patterns for generated points
   typedef enum int {VEL_RANDOM, VEL_SMALL, VEL_EXTREME} vel_mode_type;

   typedef struct {
      logic signed [31:0] vel_u, vel_v, vel_w;
      logic signed [31:0] x_coord, y_coord, z_coord;
   } point_type;

   typedef struct {
      logic signed [31:0] vort_x, vort_y, vort_z;
      logic [5:0]         pos_i, pos_j;
      logic [11:0]        pos_k;
      logic               last_point, spacing_error;
   } curl_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_we = 0;
   logic [1:0]   csr_index = vst_pkg::CSR_SIZE_X;
   logic [12:0]  csr_wdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;

   vorticity_stencil_3d uut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the block's registers and stores
   logic [6:0]  sz_x = vst_pkg::SIZE_X_RST, sz_y = vst_pkg::SIZE_Y_RST;
   logic [12:0] sz_z = vst_pkg::SIZE_Z_RST;
   logic [4:0]  ghost_n = vst_pkg::GHOST_RST;
   int          u_pl[2*PLANE], v_pl[2*PLANE], w_pl[2*PLANE];
   int          x_tab[64], y_tab[64], z_hist[2];
   int          cnt_i = 0, cnt_j = 0, cnt_k = 0;

   curl_type curl_q[$];
   int    fails = 0;
   int    cycles = 0;
   int    hold_left = 0;
   int    sent = 0;

   // Coordinate ramps and velocity pattern of the current grid
   int           x_base, x_step, y_base, y_step, z_base, z_step;
   vel_mode_type vel_mode;
   bit           noisy;

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int clampi(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Central-difference slope; flag and zero on non-positive spacing
   function automatic longint slope(input longint fh, input longint fl, input longint ch,
                                    input longint cl, inout bit err);
      longint den;
      den = ch - cl;
      if (den <= 0) begin
         err = 1;
         return 0;
      end
      return sat32(((fh - fl) * 65536) / den);
   endfunction

   // Update the shadow state for one request; queue the curl it completes
   function automatic void predict_curl(input point_type p);
      int nx, ny, nz, g, ci, cj, kin, kc, wr, cb;
      bit err;
      longint dudy, dudz, dvdx, dvdz, dwdx, dwdy;
      curl_type r;
      nx = clampi(sz_x, 3, 64);
      ny = clampi(sz_y, 3, 64);
      nz = clampi(sz_z, 3, 4096);
      g = ghost_n < 1 ? 1 : ghost_n;
      ci = cnt_i; cj = cnt_j; kin = cnt_k;
      wr = (kin % 2) * PLANE + cj * 64 + ci;
      if (kin >= 1) begin
         kc = kin - 1;
         if (ci >= g && ci + g < nx && cj >= g && cj + g < ny && kc >= g && kc + g < nz) begin
            cb = (kc % 2) * PLANE + cj * 64 + ci;
            err = 0;
            dudy = slope(u_pl[cb+64], u_pl[cb-64], y_tab[cj+1], y_tab[cj-1], err);
            dudz = slope(p.vel_u, u_pl[wr], p.z_coord, z_hist[0], err);
            dvdx = slope(v_pl[cb+1], v_pl[cb-1], x_tab[ci+1], x_tab[ci-1], err);
            dvdz = slope(p.vel_v, v_pl[wr], p.z_coord, z_hist[0], err);
            dwdx = slope(w_pl[cb+1], w_pl[cb-1], x_tab[ci+1], x_tab[ci-1], err);
            dwdy = slope(w_pl[cb+64], w_pl[cb-64], y_tab[cj+1], y_tab[cj-1], err);
            r.vort_x = 32'(sat32(dwdy - dvdz));
            r.vort_y = 32'(sat32(dudz - dwdx));
            r.vort_z = 32'(sat32(dvdx - dudy));
            r.pos_i = 6'(ci);
            r.pos_j = 6'(cj);
            r.pos_k = 12'(kc);
            r.last_point = (ci + g + 1 == nx && cj + g + 1 == ny && kc + g + 1 == nz);
            r.spacing_error = err;
            curl_q.push_back(r);
         end
      end
      u_pl[wr] = p.vel_u;
      v_pl[wr] = p.vel_v;
      w_pl[wr] = p.vel_w;
      x_tab[ci] = p.x_coord;
      y_tab[cj] = p.y_coord;
      // Advance the raster counters
      if (ci + 1 < nx) begin
         cnt_i = ci + 1;
      end else begin
         cnt_i = 0;
         if (cj + 1 < ny) begin
            cnt_j = cj + 1;
         end else begin
            cnt_j = 0;
            z_hist[0] = z_hist[1];
            z_hist[1] = p.z_coord;
            cnt_k = (kin + 1 < nz) ? kin + 1 : 0;
         end
      end
   endfunction

   // Compare one result against the oldest expected curl
   task automatic check_curl();
      curl_type e;
      if (curl_q.size() == 0) begin
         $error("unexpected result tdata=%h", rsp_tdata);
         fails++;
         return;
      end
      e = curl_q.pop_front();
      if (rsp_tdata[31:0] !== e.vort_x) begin
         $error("vort_x: expected %h, got %h", e.vort_x, rsp_tdata[31:0]); fails++;
      end
      if (rsp_tdata[63:32] !== e.vort_y) begin
         $error("vort_y: expected %h, got %h", e.vort_y, rsp_tdata[63:32]); fails++;
      end
      if (rsp_tdata[95:64] !== e.vort_z) begin
         $error("vort_z: expected %h, got %h", e.vort_z, rsp_tdata[95:64]); fails++;
      end
      if (rsp_tdata[101:96] !== e.pos_i) begin
         $error("pos_i: expected %0d, got %0d", e.pos_i, rsp_tdata[101:96]); fails++;
      end
      if (rsp_tdata[107:102] !== e.pos_j) begin
         $error("pos_j: expected %0d, got %0d", e.pos_j, rsp_tdata[107:102]); fails++;
      end
      if (rsp_tdata[119:108] !== e.pos_k) begin
         $error("pos_k: expected %0d, got %0d", e.pos_k, rsp_tdata[119:108]); fails++;
      end
      if (rsp_tlast !== e.last_point) begin
         $error("last_point: expected %b, got %b", e.last_point, rsp_tlast); fails++;
      end
      if (rsp_tuser !== e.spacing_error) begin
         $error("spacing_error: expected %b, got %b", e.spacing_error, rsp_tuser); fails++;
      end
   endtask

   // Result side: check accepted results, then pick the next ready
   int stall_left = 0, calm_left = 0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) check_curl();
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1;
      end else if ($urandom_range(0, 99) < 2) begin
         calm_left = $urandom_range(50, 300);
         rsp_tready <= 1;
      end else if ($urandom_range(0, 9) < 3) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Write one register, junk in the unused upper bits; counters restart
   task automatic write_reg(input logic [1:0] idx, input int val, input int w);
      logic [12:0] d;
      d = 13'($urandom);
      d = 13'((d >> w << w) | (val & ((1 << w) - 1)));
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      case (idx)
         vst_pkg::CSR_SIZE_X: sz_x = d[6:0];
         vst_pkg::CSR_SIZE_Y: sz_y = d[6:0];
         vst_pkg::CSR_SIZE_Z: sz_z = d[12:0];
         vst_pkg::CSR_GHOST:  ghost_n = d[4:0];
      endcase
      cnt_i = 0; cnt_j = 0; cnt_k = 0;
   endtask

   task automatic set_grid(input int sx, input int sy, input int sz, input int g);
      write_reg(vst_pkg::CSR_SIZE_X, sx, 7);
      write_reg(vst_pkg::CSR_SIZE_Y, sy, 7);
      write_reg(vst_pkg::CSR_SIZE_Z, sz, 13);
      write_reg(vst_pkg::CSR_GHOST, g, 5);
      csr_we <= 0;
   endtask

   // Stop sending and let every expected curl come back
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (curl_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int pick_vel();
      case (vel_mode)
         VEL_SMALL:   return $signed(16'($urandom)) * int'($urandom_range(1, 8));
         VEL_EXTREME: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default:     return $urandom;
      endcase
   endfunction

   // Build the request for the point the block expects next
   function automatic point_type next_point();
      point_type p;
      p.vel_u = pick_vel();
      p.vel_v = pick_vel();
      p.vel_w = pick_vel();
      if (noisy) begin
         p.x_coord = $urandom; p.y_coord = $urandom; p.z_coord = $urandom;
      end else begin
         p.x_coord = x_base + cnt_i * x_step;
         p.y_coord = y_base + cnt_j * y_step;
         p.z_coord = z_base + cnt_k * z_step;
      end
      return p;
   endfunction

   // Offer one request, after a random gap when gaps is set, and wait for the handshake
   task automatic send_point(input bit gaps);
      point_type p;
      int gap;
      p = next_point();
      gap = 0;
      if (gaps) begin
         case ($urandom_range(0, 9))
            0, 1, 2:    gap = $urandom_range(1, 3);
            3:          gap = $urandom_range(10, 40);
            default:    gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {p.z_coord, p.y_coord, p.x_coord, p.vel_w, p.vel_v, p.vel_u};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_curl(p);
      sent++;
   endtask

   task automatic new_ramps(input int xs, input int ys, input int zs);
      x_base = $urandom; y_base = $urandom; z_base = $urandom;
      x_base = x_base >>> 2; y_base = y_base >>> 2; z_base = z_base >>> 2;
      x_step = xs; y_step = ys; z_step = zs;
   endtask

   task automatic send_points(input int n, input bit gaps);
      repeat (n) send_point(gaps);
   endtask

   // Smallest grids with extreme values and bad spacings
   task automatic test_directed();
      set_grid(3, 3, 3, 1);
      noisy = 0;
      vel_mode = VEL_EXTREME;
      // zero spacing along y, negative along z
      new_ramps(1, 0, -32'h10000);
      send_points(27, 0);
      // tiny spacing: every nonzero difference saturates its quotient
      new_ramps(1, 1, 1);
      send_points(27, 0);
      drain();
   endtask

   // Out-of-range sizes, ghost extremes and a huge depth cut short
   task automatic test_register_extremes();
      noisy = 0;
      vel_mode = VEL_SMALL;
      new_ramps(32'h8000, 32'h20000, 32'h1000);
      // sizes clamp to 64 x 3 x 3, ghost zero acts as one; stop just after the last curl's point
      set_grid(127, 1, 0, 0);
      send_points(64 * 3 * 2 + 64 * 2, 1);
      drain();
      // ghost wider than half the grid: no interior
      set_grid(5, 5, 5, 31);
      send_points(40, 1);
      drain();
      // deepest grid, stopped after a few planes
      set_grid(3, 4, 8191, 1);
      send_points(3 * 4 * 5 + 2, 1);
      drain();
   endtask

   // Hold the result side off while requests keep coming
   task automatic test_backpressure();
      set_grid(4, 4, 4, 1);
      noisy = 0;
      vel_mode = VEL_RANDOM;
      new_ramps(32'h10000, 32'h18000, 32'h30000);
      hold_left = 3000;
      send_points(64, 0);
      drain();
   endtask

   // Random grids, mostly well formed, some noisy or cut short
   task automatic test_random_grids();
      int nx, ny, nz, g, total, n;
      sent = 0;
      while (sent < RAND_ITEMS) begin
         nx = $urandom_range(3, 8);
         ny = $urandom_range(3, 6);
         nz = $urandom_range(3, 5);
         g = (nx >= 5 && ny >= 5 && nz >= 5 && $urandom_range(0, 2) == 0) ? 2 : 1;
         set_grid(nx, ny, nz, g);
         noisy = ($urandom_range(0, 9) == 0);
         vel_mode = vel_mode_type'($urandom_range(0, 3) == 0 ? VEL_RANDOM : VEL_SMALL);
         new_ramps($urandom_range(0, 9) == 0 ? -$urandom_range(0, 32'h10000)
                                             : $urandom_range(1, 32'h40000),
                   $urandom_range(1, 32'h40000), $urandom_range(1, 32'h40000));
         total = nx * ny * nz;
         case ($urandom_range(0, 4))
            0:       n = $urandom_range(1, total - 1);
            1:       n = 2 * total;
            default: n = total;
         endcase
         send_points(n, 1);
         drain();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_grids();
      drain();
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
